[sv/rsace_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsace_pkg
// shared types and constants for the byte encryptor and nibble encoder
// ----------------------------------------------------------------------------
package rsace_pkg;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int EXP_WIDTH       = 16;
   localparam int BYTE_WIDTH      = 8;
   localparam int CIPHER_WIDTH    = 16;
   localparam int HIGH_CHAR_WIDTH = 8;
   localparam int LOW_CHAR_WIDTH  = 7;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODULUS  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXPONENT = 2'd1;

   localparam logic [CSR_DATA_WIDTH-1:0] MODULUS_RESET  = 16'd2;
   localparam logic [EXP_WIDTH-1:0]      EXPONENT_RESET = 16'd1;

   localparam logic [HIGH_CHAR_WIDTH-1:0] ENC_BASE_HIGH = 8'h40;
   localparam logic [LOW_CHAR_WIDTH-1:0]  ENC_BASE_LOW  = 7'h40;
   localparam logic [3:0]                 NIBBLE_MASK   = 4'hf;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_CHECK,
      ST_MUL,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

[sv/rsace_modmul.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsace_modmul
// bit-serial interleaved modular multiplier, one bit of a per cycle
// ----------------------------------------------------------------------------
module rsace_modmul #(
   parameter int WIDTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [WIDTH-1:0] a,
   input  wire logic [WIDTH-1:0] b,
   input  wire logic [WIDTH-1:0] n,
   output logic                  done,
   output logic [WIDTH-1:0]      result
);

   localparam int CNT_WIDTH = $clog2(WIDTH + 1);

   logic                 busy_ff, busy_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0]     r_ff, r_in;
   logic [WIDTH-1:0]     a_ff, a_in;
   logic [WIDTH-1:0]     b_ff, b_in;

   logic [WIDTH:0]       dbl;
   logic [WIDTH:0]       dbl_red;
   logic [WIDTH:0]       sum;
   logic [WIDTH:0]       sum_red;
   logic [WIDTH-1:0]     step_r;

   // r = 2r mod n, then r = r + (bit ? b : 0) mod n
   always_comb begin
      dbl = {r_ff, 1'b0};
      if (dbl >= {1'b0, n}) begin
         dbl_red = dbl - {1'b0, n};
      end else begin
         dbl_red = dbl;
      end
      sum = {1'b0, dbl_red[WIDTH-1:0]} + (a_ff[WIDTH-1] ? {1'b0, b_ff} : '0);
      if (sum >= {1'b0, n}) begin
         sum_red = sum - {1'b0, n};
      end else begin
         sum_red = sum;
      end
      step_r = sum_red[WIDTH-1:0];
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      r_in    = r_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_WIDTH'(WIDTH);
         r_in    = '0;
         a_in    = a;
         b_in    = b;
      end else if (busy_ff) begin
         r_in   = step_r;
         a_in   = {a_ff[WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_WIDTH'(1);
         if (cnt_ff == CNT_WIDTH'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   assign done   = busy_ff && (cnt_ff == CNT_WIDTH'(1));
   assign result = step_r;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      r_ff <= r_in;
      a_ff <= a_in;
      b_ff <= b_in;
   end

endmodule
`default_nettype wire

[sv/rsa_char_encrypt_nibble_encode.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsa_char_encrypt_nibble_encode
// textbook rsa encryption of one byte with two printable nibble characters
// ----------------------------------------------------------------------------
// Each accepted byte m gives one word: c = m^e mod n and the characters
// 0x40|(c>>4) (low 8 bits) and 0x40|(c&0xf). The exponent is worked right to
// left: square the base when even, multiply into the accumulator and
// decrement when odd. All arithmetic runs through one bit-serial modular
// multiplier, which the state machine starts once per product and waits on.
// After the byte is accepted, the base is first reduced modulo n, then the
// squares and multiplies run one after another (popcount(e)+floor(log2 e)
// operations), then the result goes to the output register once it is free;
// the next byte can be taken in the cycle the word appears. A modulus of zero
// or one skips the multiplier and goes straight to the hand-over. req_stall
// is high while an item is in work; the result sits in an output register,
// so the next byte is taken while it waits. Write csr only while idle;
// csr_ready is always high.
// ----------------------------------------------------------------------------
module rsa_char_encrypt_nibble_encode #(
   parameter int MOD_WIDTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic [rsace_pkg::BYTE_WIDTH-1:0]       req_message_byte,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic [rsace_pkg::CIPHER_WIDTH-1:0]          rsp_cipher_value,
   output logic [rsace_pkg::HIGH_CHAR_WIDTH-1:0]       rsp_high_char,
   output logic [rsace_pkg::LOW_CHAR_WIDTH-1:0]        rsp_low_char,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [rsace_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [rsace_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   localparam int EW = rsace_pkg::EXP_WIDTH;

   rsace_pkg::state_type state_ff, state_in;

   logic [MOD_WIDTH-1:0] mod_ff, mod_in;
   logic [EW-1:0]        expcfg_ff, expcfg_in;
   logic [EW-1:0]        exp_ff, exp_in;
   logic [MOD_WIDTH-1:0] base_ff, base_in;
   logic [MOD_WIDTH-1:0] acc_ff, acc_in;
   logic                 sq_ff, sq_in;

   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [rsace_pkg::CIPHER_WIDTH-1:0]     cipher_ff, cipher_in;

   logic                 mm_start;
   logic [MOD_WIDTH-1:0] mm_a;
   logic [MOD_WIDTH-1:0] mm_b;
   logic                 mm_done;
   logic [MOD_WIDTH-1:0] mm_result;

   logic                 req_take;
   logic                 out_free;
   logic                 mod_small;
   logic [31:0]          wdata_wide;
   logic [31:0]          byte_wide;
   logic [31:0]          acc_wide;

   assign req_take   = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign mod_small  = (mod_ff < MOD_WIDTH'(2));
   assign wdata_wide = {16'd0, csr_wdata};
   assign byte_wide  = {24'd0, req_message_byte};
   assign acc_wide   = 32'(acc_ff);

   rsace_modmul #(
      .WIDTH(MOD_WIDTH)
   ) u_modmul (
      .clock (clock),
      .reset (reset),
      .start (mm_start),
      .a     (mm_a),
      .b     (mm_b),
      .n     (mod_ff),
      .done  (mm_done),
      .result(mm_result)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rsace_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = mod_small ? rsace_pkg::ST_DONE : rsace_pkg::ST_REDUCE;
            end
         end
         rsace_pkg::ST_REDUCE: begin
            if (mm_done) begin
               state_in = rsace_pkg::ST_CHECK;
            end
         end
         rsace_pkg::ST_CHECK: begin
            state_in = (exp_ff == '0) ? rsace_pkg::ST_DONE : rsace_pkg::ST_MUL;
         end
         rsace_pkg::ST_MUL: begin
            if (mm_done) begin
               state_in = rsace_pkg::ST_CHECK;
            end
         end
         rsace_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = rsace_pkg::ST_IDLE;
            end
         end
         default: state_in = rsace_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath loads
   always_comb begin
      req_stall    = 1'b1;
      mm_start     = 1'b0;
      mm_a         = base_ff;
      mm_b         = base_ff;
      exp_in       = exp_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      sq_in        = sq_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cipher_in    = cipher_ff;
      unique case (state_ff)
         rsace_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            mm_a      = byte_wide[MOD_WIDTH-1:0];
            mm_b      = MOD_WIDTH'(1);
            exp_in    = expcfg_ff;
            if (req_take) begin
               mm_start = !mod_small;
               if (mod_small) begin
                  acc_in = ((mod_ff == MOD_WIDTH'(1)) && (expcfg_ff == '0)) ?
                           MOD_WIDTH'(1) : '0;
               end else begin
                  acc_in = MOD_WIDTH'(1);
               end
            end
         end
         rsace_pkg::ST_REDUCE: begin
            if (mm_done) begin
               base_in = mm_result;
            end
         end
         rsace_pkg::ST_CHECK: begin
            if (exp_ff != '0) begin
               mm_start = 1'b1;
               sq_in    = !exp_ff[0];
               mm_b     = exp_ff[0] ? acc_ff : base_ff;
            end
         end
         rsace_pkg::ST_MUL: begin
            if (mm_done) begin
               if (sq_ff) begin
                  base_in = mm_result;
                  exp_in  = {1'b0, exp_ff[EW-1:1]};
               end else begin
                  acc_in = mm_result;
                  exp_in = exp_ff - EW'(1);
               end
            end
         end
         rsace_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               cipher_in    = acc_wide[rsace_pkg::CIPHER_WIDTH-1:0];
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // register writes
   always_comb begin
      mod_in    = mod_ff;
      expcfg_in = expcfg_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == rsace_pkg::CSR_MODULUS) begin
            mod_in = wdata_wide[MOD_WIDTH-1:0];
         end else if (csr_index == rsace_pkg::CSR_EXPONENT) begin
            expcfg_in = csr_wdata;
         end
      end
   end

   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cipher_value = cipher_ff;
   assign rsp_high_char    = rsace_pkg::ENC_BASE_HIGH | cipher_ff[11:4];
   assign rsp_low_char     = rsace_pkg::ENC_BASE_LOW |
                             {3'd0, cipher_ff[3:0] & rsace_pkg::NIBBLE_MASK};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rsace_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mod_ff       <= MOD_WIDTH'(rsace_pkg::MODULUS_RESET);
         expcfg_ff    <= rsace_pkg::EXPONENT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         mod_ff       <= mod_in;
         expcfg_ff    <= expcfg_in;
      end
      exp_ff    <= exp_in;
      base_ff   <= base_in;
      acc_ff    <= acc_in;
      sq_ff     <= sq_in;
      cipher_ff <= cipher_in;
   end

endmodule
`default_nettype wire

[bench/rsa_char_encrypt_nibble_encode_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_char_encrypt_nibble_encode_tb
// self-checking bench for the byte encryptor and nibble encoder
// ----------------------------------------------------------------------------
// Bytes are pushed through the encryptor under many modulus and exponent
// settings. Each accepted byte is predicted as m^e mod n with its two
// printable characters, and every word returned is checked against the
// oldest prediction. Directed bytes cover the edge settings (zero exponent,
// modulus zero and one, base not below the modulus, zero ciphertext), then
// random phases run with varied sender gaps, receiver stalls and one long
// receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------

class cipher_scoreboard;
   typedef struct {
      logic [rsace_pkg::CIPHER_WIDTH-1:0]    cipher;
      logic [rsace_pkg::HIGH_CHAR_WIDTH-1:0] high;
      logic [rsace_pkg::LOW_CHAR_WIDTH-1:0]  low;
   } cipher_word_type;

   cipher_word_type awaited[$];
   logic [rsace_pkg::CSR_DATA_WIDTH-1:0] modulus;
   logic [rsace_pkg::EXP_WIDTH-1:0]      exponent;
   int errors;
   int checked;

   function new();
      modulus  = rsace_pkg::MODULUS_RESET;
      exponent = rsace_pkg::EXPONENT_RESET;
      errors   = 0;
      checked  = 0;
   endfunction

   function void write_reg(logic [rsace_pkg::CSR_INDEX_WIDTH-1:0] idx,
                           logic [rsace_pkg::CSR_DATA_WIDTH-1:0] data);
      if (idx == rsace_pkg::CSR_MODULUS)
         modulus = data;
      else if (idx == rsace_pkg::CSR_EXPONENT)
         exponent = data;
   endfunction

   function cipher_word_type encrypt(logic [rsace_pkg::BYTE_WIDTH-1:0] m);
      cipher_word_type w;
      logic [63:0] base;
      logic [63:0] acc;
      logic [63:0] e;
      logic [63:0] n;
      n    = 64'(modulus);
      base = 64'(m);
      e    = 64'(exponent);
      acc  = 64'd1;
      if (n == 64'd0) begin
         acc = 64'd0;
      end else begin
         while (e != 64'd0) begin
            if (e[0] == 1'b0) begin
               base = (base * base) % n;
               e    = e >> 1;
            end else begin
               acc = (base * acc) % n;
               e   = e - 64'd1;
            end
         end
      end
      w.cipher = acc[rsace_pkg::CIPHER_WIDTH-1:0];
      w.high   = rsace_pkg::ENC_BASE_HIGH | w.cipher[11:4];
      w.low    = rsace_pkg::ENC_BASE_LOW | {3'b000, w.cipher[3:0] & rsace_pkg::NIBBLE_MASK};
      return w;
   endfunction

   function void note_byte(logic [rsace_pkg::BYTE_WIDTH-1:0] m);
      awaited.push_back(encrypt(m));
   endfunction

   function void check_word(logic [rsace_pkg::CIPHER_WIDTH-1:0] c,
                            logic [rsace_pkg::HIGH_CHAR_WIDTH-1:0] h,
                            logic [rsace_pkg::LOW_CHAR_WIDTH-1:0] l);
      cipher_word_type w;
      if (awaited.size() == 0) begin
         errors++;
         $display("%0t: unexpected word, expected none, actual cipher %h high %h low %h",
                  $time, c, h, l);
         return;
      end
      w = awaited.pop_front();
      checked++;
      if (w.cipher !== c) begin
         errors++;
         $display("%0t: cipher_value expected %h actual %h", $time, w.cipher, c);
      end
      if (w.high !== h) begin
         errors++;
         $display("%0t: high_char expected %h actual %h", $time, w.high, h);
      end
      if (w.low !== l) begin
         errors++;
         $display("%0t: low_char expected %h actual %h", $time, w.low, l);
      end
   endfunction

   function int pending();
      return awaited.size();
   endfunction
endclass

module rsa_char_encrypt_nibble_encode_tb;

   typedef enum int {
      IDLE_NONE,
      IDLE_SEND,
      IDLE_RECV,
      IDLE_BOTH
   } idle_mode_type;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_stall;
   logic [rsace_pkg::BYTE_WIDTH-1:0]      req_message_byte = '0;
   logic                                  rsp_valid;
   logic                                  rsp_stall = 1'b0;
   logic [rsace_pkg::CIPHER_WIDTH-1:0]    rsp_cipher_value;
   logic [rsace_pkg::HIGH_CHAR_WIDTH-1:0] rsp_high_char;
   logic [rsace_pkg::LOW_CHAR_WIDTH-1:0]  rsp_low_char;
   logic                                  csr_valid = 1'b0;
   logic                                  csr_ready;
   logic [rsace_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [rsace_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   cipher_scoreboard sb;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left = 0;
   bit hold_req = 1'b0;
   int bytes_sent = 0;
   int csr_writes = 0;

   rsa_char_encrypt_nibble_encode #(.MOD_WIDTH(16)) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_message_byte (req_message_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_cipher_value (rsp_cipher_value),
      .rsp_high_char    (rsp_high_char),
      .rsp_low_char     (rsp_low_char),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   initial begin
      #40_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // receiver stall, with an occasional long hold-off
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left == 0 && hold_req) begin
            hold_left = 2500;
            hold_req  = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0)
            sb.check_word(rsp_cipher_value, rsp_high_char, rsp_low_char);
      end
   end

   task automatic send_byte(input logic [rsace_pkg::BYTE_WIDTH-1:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_message_byte <= b;
      forever begin
         @(posedge clock);
         if (req_stall == 1'b0)
            break;
      end
      sb.note_byte(b);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [rsace_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [rsace_pkg::CSR_DATA_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      forever begin
         @(posedge clock);
         if (csr_ready === 1'b1)
            break;
      end
      sb.write_reg(idx, data);
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_idle(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         IDLE_SEND: begin
            send_idle_pct = 58;
            recv_idle_pct = 0;
         end
         IDLE_RECV: begin
            send_idle_pct = 0;
            recv_idle_pct = 58;
         end
         default: begin
            send_idle_pct = 24;
            recv_idle_pct = 24;
         end
      endcase
   endtask

   initial begin
      logic [rsace_pkg::CSR_DATA_WIDTH-1:0] mod_v;
      logic [rsace_pkg::EXP_WIDTH-1:0]      exp_v;
      int phase;
      int k;
      sb = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset settings, then the edge settings
      set_idle(IDLE_NONE);
      send_byte(8'd0);
      send_byte(8'd255);
      send_byte(8'd1);
      send_byte(8'd128);
      drain();
      write_csr(rsace_pkg::CSR_MODULUS, 16'hffff);
      write_csr(rsace_pkg::CSR_EXPONENT, 16'hffff);
      send_byte(8'd0);
      send_byte(8'd255);
      send_byte(8'd2);
      send_byte(8'd254);
      drain();
      write_csr(rsace_pkg::CSR_MODULUS, 16'd0);
      send_byte(8'd7);
      send_byte(8'd255);
      drain();
      write_csr(rsace_pkg::CSR_MODULUS, 16'd1);
      write_csr(rsace_pkg::CSR_EXPONENT, 16'd0);
      send_byte(8'd5);
      send_byte(8'd0);
      drain();
      write_csr(rsace_pkg::CSR_EXPONENT, 16'd3);
      send_byte(8'd9);
      drain();
      write_csr(rsace_pkg::CSR_MODULUS, 16'd300);
      write_csr(rsace_pkg::CSR_EXPONENT, 16'd0);
      send_byte(8'd0);
      send_byte(8'd200);
      drain();
      write_csr(rsace_pkg::CSR_MODULUS, 16'd100);
      write_csr(rsace_pkg::CSR_EXPONENT, 16'd1);
      send_byte(8'd255);
      send_byte(8'd100);
      drain();
      write_csr(rsace_pkg::CSR_MODULUS, 16'd16);
      write_csr(rsace_pkg::CSR_EXPONENT, 16'd2);
      send_byte(8'd4);
      send_byte(8'd12);
      drain();
      write_csr(rsace_pkg::CSR_MODULUS, 16'd13);
      send_byte(8'd200);
      drain();

      // random phases
      for (phase = 0; phase < 12; phase++) begin
         case (phase)
            0: begin
               mod_v = 16'hffff;
               exp_v = 16'hffff;
            end
            1: begin
               mod_v = 16'd2;
               exp_v = 16'd0;
            end
            2: begin
               mod_v = 16'hffff;
               exp_v = 16'd1;
            end
            4: begin
               mod_v = 16'($urandom_range(2, 65535));
               exp_v = 16'($urandom_range(2, 20));
            end
            default: begin
               if ($urandom_range(0, 99) < 25)
                  mod_v = 16'($urandom_range(2, 300));
               else
                  mod_v = 16'($urandom_range(2, 65535));
               if ($urandom_range(0, 99) < 30)
                  exp_v = 16'($urandom_range(0, 40));
               else
                  exp_v = 16'($urandom_range(0, 65535));
            end
         endcase
         write_csr(rsace_pkg::CSR_MODULUS, mod_v);
         write_csr(rsace_pkg::CSR_EXPONENT, exp_v);
         if (phase == 6) begin
            write_csr(2'd2, 16'($urandom_range(0, 65535)));
            write_csr(2'd3, 16'($urandom_range(0, 65535)));
         end
         set_idle(idle_mode_type'(phase % 4));
         if (phase == 4)
            hold_req = 1'b1;
         for (k = 0; k < 45; k++) begin
            if ($urandom_range(0, 99) < 10)
               send_byte($urandom_range(0, 1) ? 8'd255 : 8'd0);
            else
               send_byte(8'($urandom_range(0, 255)));
         end
         drain();
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(negedge clock);
      repeat (600) @(negedge clock);
      $display("%0d bytes encrypted, %0d words checked, %0d register writes", bytes_sent,
               sb.checked, csr_writes);
      $display("settings spanned moduli 0, 1 and 65535 and exponents 0 to 65535");
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[rsa_char_encrypt_nibble_encode.f]
sv/rsace_pkg.sv
sv/rsace_modmul.sv
sv/rsa_char_encrypt_nibble_encode.sv
bench/rsa_char_encrypt_nibble_encode_tb.sv
